[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the vector ALU; define NO_ASSERTIONS to drop them
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define VA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("vector alu: property violated");
// expression must never be true outside reset
`define VA_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("vector alu: forbidden condition seen");
`else
`define VA_ASSERT(lbl, clk, rstn, prop)
`define VA_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[rtl/core/va_pkg.sv]
// ----------------------------------------------------------------------------
// va_pkg
// Shared types, opcodes and helpers of the vector ALU
// ----------------------------------------------------------------------------
`default_nettype none
package va_pkg;

    localparam int OP_W      = 4;
    localparam int NZ_W      = 16;
    localparam int S_TDATA_W = 264;
    localparam int M_TDATA_W = 168;

    localparam logic [OP_W-1:0] OP_NEG    = 4'd0;
    localparam logic [OP_W-1:0] OP_DOT    = 4'd1;
    localparam logic [OP_W-1:0] OP_CROSS  = 4'd2;
    localparam logic [OP_W-1:0] OP_NORM   = 4'd3;
    localparam logic [OP_W-1:0] OP_HOMO   = 4'd4;
    localparam logic [OP_W-1:0] OP_ADD    = 4'd5;
    localparam logic [OP_W-1:0] OP_SUB    = 4'd6;
    localparam logic [OP_W-1:0] OP_SCALE  = 4'd7;
    localparam logic [OP_W-1:0] OP_NORMAL = 4'd8;

    typedef logic signed [31:0] word_t;

    localparam word_t SAT_MAX = 32'sh7FFF_FFFF;
    localparam word_t SAT_MIN = 32'sh8000_0000;
    localparam logic signed [65:0] MAX66 = 66'sh7FFFFFFF;
    localparam logic signed [65:0] MIN66 = 66'sh3FFFFFFFF80000000;

    typedef struct packed {
        logic [OP_W-1:0] op;
        word_t           a_w;
        word_t [2:0]     res;
        word_t [2:0]     nvec;
        word_t           dot;
    } payload_t;

    function automatic word_t sat66(input logic signed [65:0] v);
        word_t r;
        if (v > MAX66) begin
            r = SAT_MAX;
        end else if (v < MIN66) begin
            r = SAT_MIN;
        end else begin
            r = word_t'(v[31:0]);
        end
        return r;
    endfunction

    function automatic logic [31:0] mag32(input word_t v);
        logic [31:0] u;
        u = v;
        return v[31] ? (~u + 32'd1) : u;
    endfunction

endpackage
`default_nettype wire

[rtl/core/va_lane.sv]
// ----------------------------------------------------------------------------
// va_lane
// One vector component: products, cross term, element ops and squared size
// ----------------------------------------------------------------------------
`default_nettype none
module va_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [va_pkg::OP_W-1:0] op,
    input  va_pkg::word_t           a_i,
    input  va_pkg::word_t           b_i,
    input  va_pkg::word_t           a_j,
    input  va_pkg::word_t           b_k,
    input  va_pkg::word_t           a_k,
    input  va_pkg::word_t           b_j,
    input  va_pkg::word_t           factor,
    output logic signed [63:0]      prod_s2,
    output va_pkg::word_t           res_s3,
    output va_pkg::word_t           nvec_s3,
    output logic [63:0]             sq_s3
);
    import va_pkg::*;

    logic signed [63:0] pc1_reg, pc2_reg, pm_reg, prod_reg;
    word_t              a_reg, b_reg, mult;
    logic [OP_W-1:0]    op_reg;
    logic signed [65:0] diff, a66, b66, pm66;
    word_t              cross_sat, res_next, nvec_next;
    word_t              res_reg, nvec_reg, res3_reg, nvec3_reg;
    logic [31:0]        mag;
    logic [63:0]        sq_reg;

    assign mult = (op == OP_SCALE) ? factor : b_i;

    always_ff @(posedge aclk) begin
        if (en) begin
            pc1_reg  <= a_j * b_k;
            pc2_reg  <= a_k * b_j;
            pm_reg   <= a_i * mult;
            a_reg    <= a_i;
            b_reg    <= b_i;
            op_reg   <= op;
            res_reg  <= res_next;
            nvec_reg <= nvec_next;
            prod_reg <= pm_reg;
            res3_reg <= res_reg;
            nvec3_reg <= nvec_reg;
            sq_reg   <= mag * mag;
        end
    end

    always_comb begin
        diff = $signed({{2{pc1_reg[63]}}, pc1_reg}) - $signed({{2{pc2_reg[63]}}, pc2_reg});
        a66  = $signed({{34{a_reg[31]}}, a_reg});
        b66  = $signed({{34{b_reg[31]}}, b_reg});
        pm66 = $signed({{2{pm_reg[63]}}, pm_reg});
        cross_sat = sat66(diff >>> FRAC_BITS);
        case (op_reg)
            OP_NEG:              res_next = sat66(66'sd0 - a66);
            OP_ADD:              res_next = sat66(a66 + b66);
            OP_SUB:              res_next = sat66(a66 - b66);
            OP_SCALE:            res_next = sat66(pm66 >>> FRAC_BITS);
            OP_CROSS, OP_NORMAL: res_next = cross_sat;
            default:             res_next = '0;
        endcase
        // vector to be normalised or divided
        nvec_next = (op_reg == OP_NORMAL) ? cross_sat : a_reg;
    end

    assign mag     = mag32(nvec_reg);
    assign prod_s2 = prod_reg;
    assign res_s3  = res3_reg;
    assign nvec_s3 = nvec3_reg;
    assign sq_s3   = sq_reg;

endmodule
`default_nettype wire

[rtl/core/va_isqrt.sv]
// ----------------------------------------------------------------------------
// va_isqrt
// Pipelined integer square root, one result bit per stage, 32 stages
// ----------------------------------------------------------------------------
`default_nettype none
module va_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] v,
    output logic [31:0] root
);
    localparam int STAGES = 32;

    logic [33:0] rem_reg  [STAGES];
    logic [31:0] root_reg [STAGES];
    logic [63:0] v_reg    [STAGES];
    logic [33:0] rem_next [STAGES];
    logic [31:0] root_next[STAGES];
    logic [63:0] v_next   [STAGES];

    always_comb begin
        logic [33:0] r_p;
        logic [31:0] q_p;
        logic [63:0] v_p;
        logic [35:0] r_n, trial;
        logic        ge;
        for (int k = 0; k < STAGES; k++) begin
            if (k == 0) begin
                r_p = '0;
                q_p = '0;
                v_p = v;
            end else begin
                r_p = rem_reg[k-1];
                q_p = root_reg[k-1];
                v_p = v_reg[k-1];
            end
            r_n   = {r_p, v_p[63:62]};
            trial = {2'b00, q_p, 2'b01};
            ge    = (r_n >= trial);
            rem_next[k]  = ge ? 34'(r_n - trial) : r_n[33:0];
            root_next[k] = {q_p[30:0], ge};
            v_next[k]    = {v_p[61:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                v_reg[k]    <= v_next[k];
            end
        end
    end

    assign root = root_reg[STAGES-1];

endmodule
`default_nettype wire

[rtl/core/va_div.sv]
// ----------------------------------------------------------------------------
// va_div
// Pipelined unsigned divider for (num << FRAC_BITS) / den, one bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module va_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [31:0]             num_mag,
    input  logic                    neg_i,
    input  logic [31:0]             den,
    output logic [32+FRAC_BITS-1:0] quo,
    output logic                    neg_o
);
    localparam int QW = 32 + FRAC_BITS;

    logic [QW-1:0] n_reg   [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [31:0]   rem_reg [QW];
    logic [31:0]   den_reg [QW];
    logic          neg_reg [QW];
    logic [QW-1:0] n_next  [QW];
    logic [QW-1:0] quo_next[QW];
    logic [31:0]   rem_next[QW];

    always_comb begin
        logic [QW-1:0] n_p, q_p;
        logic [31:0]   r_p, d_p;
        logic [32:0]   r_n;
        logic          ge;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                n_p = {num_mag, {FRAC_BITS{1'b0}}};
                q_p = '0;
                r_p = '0;
                d_p = den;
            end else begin
                n_p = n_reg[k-1];
                q_p = quo_reg[k-1];
                r_p = rem_reg[k-1];
                d_p = den_reg[k-1];
            end
            r_n = {r_p, n_p[QW-1]};
            ge  = (r_n >= {1'b0, d_p});
            rem_next[k] = ge ? 32'(r_n - {1'b0, d_p}) : r_n[31:0];
            quo_next[k] = {q_p[QW-2:0], ge};
            n_next[k]   = {n_p[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < QW; k++) begin
                n_reg[k]   <= n_next[k];
                quo_reg[k] <= quo_next[k];
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= (k == 0) ? den : den_reg[(k == 0) ? 0 : k-1];
                neg_reg[k] <= (k == 0) ? neg_i : neg_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign quo   = quo_reg[QW-1];
    assign neg_o = neg_reg[QW-1];

endmodule
`default_nettype wire

[rtl/core/vector3_alu.sv]
// ----------------------------------------------------------------------------
// vector3_alu
// Homogeneous vector ALU in signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
// Usage: one beat on the s_ channel carries an opcode, vectors a and b and a
// scale factor; exactly one result beat leaves on the m_ channel for each
// input beat, in order. Results saturate to 32 bits.
// Pipeline: every item flows through the 32-stage square root and the
// 32 + FRAC_BITS stage dividers, whatever its opcode.
// Throughput: one beat per cycle; the whole pipeline moves as one and only
// holds while the output register is full and m_tready is low, so s_tready
// follows m_tready combinationally when the output is occupied.
// Reset: aresetn (synchronous, active low) empties the pipeline and sets
// near_zero to 1. near_zero is written through cfg_wr_en / cfg_wr_data and
// should only change while no beats are in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vector3_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // op, a_x, a_y, a_z, a_w, b_x, b_y, b_z, factor (lowest bit first)
    input  logic [va_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // r_x, r_y, r_z, r_w, dot_out, ok (lowest bit first)
    output logic [va_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [va_pkg::NZ_W-1:0]        cfg_wr_data
);
    import va_pkg::*;

    localparam int QW   = 32 + FRAC_BITS;
    localparam int PL_D = 34 + QW;
    localparam int LAT  = 37 + QW;
    localparam logic [QW-1:0] Q_LIM = {{(QW-32){1'b0}}, 32'h8000_0000};
    localparam word_t W_ONE = word_t'(32'd1 << FRAC_BITS);

    logic            en;
    logic [NZ_W-1:0] near_zero_reg;
    logic [LAT:1]    vld_reg;
    logic            m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg, out_next;

    logic [OP_W-1:0] s_op;
    word_t           a_v[3], b_v[3], s_factor;

    logic [OP_W-1:0] op_s1_reg, op_s2_reg, op_s3_reg;
    word_t           aw_s1_reg, aw_s2_reg, aw_s3_reg;

    logic signed [63:0] lane_prod[3];
    word_t              lane_res[3], lane_nvec[3];
    logic [63:0]        lane_sq[3];

    word_t       dot_reg;
    logic [63:0] sumsq_reg;
    payload_t    pl_d;
    payload_t    pl_reg[PL_D];
    logic [31:0] root;

    logic [31:0] den_reg, sel_den;
    logic [31:0] mag_reg[3];
    logic        neg_reg[3];
    logic        deg_reg[QW+1];
    logic        sel_deg, sel_homo;
    payload_t    pl_s;

    logic [QW-1:0] quo[3];
    logic          quo_neg[3];

    payload_t pf;
    word_t    dv[3], rx, ry, rz, rw, rdot;
    logic     rok;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign s_op     = s_tdata[3:0];
    assign a_v[0]   = s_tdata[35:4];
    assign a_v[1]   = s_tdata[67:36];
    assign a_v[2]   = s_tdata[99:68];
    assign b_v[0]   = s_tdata[163:132];
    assign b_v[1]   = s_tdata[195:164];
    assign b_v[2]   = s_tdata[227:196];
    assign s_factor = s_tdata[259:228];

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_zero_reg <= NZ_W'(1);
            vld_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                near_zero_reg <= cfg_wr_data;
            end
            if (en) begin
                vld_reg      <= {vld_reg[LAT-1:1], s_tvalid};
                m_tvalid_reg <= vld_reg[LAT];
            end
        end
    end

    // element lanes
    for (genvar i = 0; i < 3; i++) begin : g_lane
        va_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk    (aclk),
            .en      (en),
            .op      (s_op),
            .a_i     (a_v[i]),
            .b_i     (b_v[i]),
            .a_j     (a_v[(i+1)%3]),
            .b_k     (b_v[(i+2)%3]),
            .a_k     (a_v[(i+2)%3]),
            .b_j     (b_v[(i+1)%3]),
            .factor  (s_factor),
            .prod_s2 (lane_prod[i]),
            .res_s3  (lane_res[i]),
            .nvec_s3 (lane_nvec[i]),
            .sq_s3   (lane_sq[i])
        );
    end

    // merge: dot sum, payload build, sum of squares
    always_comb begin
        pl_d.op  = op_s3_reg;
        pl_d.a_w = aw_s3_reg;
        pl_d.dot = dot_reg;
        for (int i = 0; i < 3; i++) begin
            pl_d.res[i]  = lane_res[i];
            pl_d.nvec[i] = lane_nvec[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_s1_reg <= s_op;
            op_s2_reg <= op_s1_reg;
            op_s3_reg <= op_s2_reg;
            aw_s1_reg <= s_tdata[131:100];
            aw_s2_reg <= aw_s1_reg;
            aw_s3_reg <= aw_s2_reg;
            dot_reg   <= sat66(($signed({{2{lane_prod[0][63]}}, lane_prod[0]})
                                + $signed({{2{lane_prod[1][63]}}, lane_prod[1]})
                                + $signed({{2{lane_prod[2][63]}}, lane_prod[2]}))
                               >>> FRAC_BITS);
            sumsq_reg <= lane_sq[0] + lane_sq[1] + lane_sq[2];
            pl_reg[0] <= pl_d;
            for (int k = 1; k < PL_D; k++) begin
                pl_reg[k] <= pl_reg[k-1];
            end
        end
    end

    va_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .v    (sumsq_reg),
        .root (root)
    );

    // divisor select and degenerate test, aligned with the root
    assign pl_s     = pl_reg[32];
    assign sel_homo = (pl_s.op == OP_HOMO);
    assign sel_den  = sel_homo ? mag32(pl_s.a_w) : root;
    assign sel_deg  = (sel_den == 32'd0) || (sel_den < {{(32-NZ_W){1'b0}}, near_zero_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg    <= sel_den;
            deg_reg[0] <= sel_deg;
            for (int i = 0; i < 3; i++) begin
                mag_reg[i] <= mag32(pl_s.nvec[i]);
                neg_reg[i] <= pl_s.nvec[i][31] ^ (sel_homo & pl_s.a_w[31]);
            end
            for (int k = 1; k <= QW; k++) begin
                deg_reg[k] <= deg_reg[k-1];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        va_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (mag_reg[i]),
            .neg_i   (neg_reg[i]),
            .den     (den_reg),
            .quo     (quo[i]),
            .neg_o   (quo_neg[i])
        );
    end

    // result select
    assign pf = pl_reg[PL_D-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (quo_neg[i]) begin
                dv[i] = (quo[i] > Q_LIM) ? SAT_MIN : word_t'(32'd0 - quo[i][31:0]);
            end else begin
                dv[i] = (quo[i] >= Q_LIM) ? SAT_MAX : word_t'(quo[i][31:0]);
            end
        end
        rx   = '0;
        ry   = '0;
        rz   = '0;
        rw   = '0;
        rdot = '0;
        rok  = 1'b1;
        case (pf.op)
            OP_NEG, OP_CROSS, OP_ADD, OP_SUB, OP_SCALE: begin
                rx = pf.res[0];
                ry = pf.res[1];
                rz = pf.res[2];
                rw = pf.a_w;
            end
            OP_DOT: begin
                rdot = pf.dot;
            end
            OP_NORM, OP_HOMO, OP_NORMAL: begin
                if (deg_reg[QW]) begin
                    // degenerate: hand back the vector that was to be divided
                    rx  = pf.nvec[0];
                    ry  = pf.nvec[1];
                    rz  = pf.nvec[2];
                    rw  = (pf.op == OP_NORMAL) ? '0 : pf.a_w;
                    rok = 1'b0;
                end else begin
                    rx = dv[0];
                    ry = dv[1];
                    rz = dv[2];
                    rw = (pf.op == OP_HOMO) ? W_ONE : '0;
                end
            end
            default: begin
                rok = 1'b0;
            end
        endcase
        out_next = {7'd0, rok, rdot, rw, rz, ry, rx};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= out_next;
        end
    end

    `VA_ASSERT(a_dot_alone, aclk, aresetn, m_tvalid && (m_tdata[159:128] != 32'd0) |-> (m_tdata[127:0] == 128'd0) && m_tdata[160])
    `VA_ASSERT(a_free_accept, aclk, aresetn, !m_tvalid |-> s_tready)
    `VA_ASSERT(a_stall_freeze, aclk, aresetn, !s_tready |=> $stable(vld_reg))
    `VA_ASSERT_NEVER(a_pad_zero, aclk, aresetn, m_tvalid && (m_tdata[167:161] != 7'd0))

endmodule
`default_nettype wire

[tb/vector3_alu_checker.sv]
// ----------------------------------------------------------------------------
// vector3_alu_checker
// Watches both streams and the near_zero register write port, works out the
// expected result of every input beat and compares it with the result beats
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module vector3_alu_checker (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [va_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [va_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                         cfg_wr_en,
    input  wire logic [va_pkg::NZ_W-1:0]      cfg_wr_data,
    output int                                fail_count,
    output int                                pending
);
    import va_pkg::*;

    localparam int FRAC = 16;

    typedef struct packed {
        logic  ok;
        word_t dot;
        word_t w;
        word_t z;
        word_t y;
        word_t x;
    } alu_result_t;

    alu_result_t result_q[$];
    logic [NZ_W-1:0] threshold;

    function automatic word_t clamp(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -66'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // (num << FRAC) / den, truncated toward zero
    function automatic word_t fix_div(input word_t num, input logic [63:0] den_mag,
                                      input logic den_neg);
        logic [63:0] q;
        logic signed [65:0] s;
        q = ({32'd0, mag32(num)} << FRAC) / den_mag;
        s = $signed({2'b00, q});
        return clamp((num[31] != den_neg) ? -s : s);
    endfunction

    function automatic logic unit_vec(input logic [NZ_W-1:0] nz, inout word_t v[3]);
        longint unsigned sq, len;
        sq = 0;
        for (int i = 0; i < 3; i++) sq += {32'd0, mag32(v[i])} * {32'd0, mag32(v[i])};
        len = root64(sq);
        if (len == 0 || len < nz) return 1'b0;
        for (int i = 0; i < 3; i++) v[i] = fix_div(v[i], len, 1'b0);
        return 1'b1;
    endfunction

    function automatic alu_result_t alu_predict(input logic [S_TDATA_W-1:0] d,
                                                input logic [NZ_W-1:0] nz);
        logic [OP_W-1:0] op;
        word_t a[4], b[3], f, v[3];
        logic signed [65:0] acc;
        alu_result_t r;
        op = d[3:0];
        for (int i = 0; i < 4; i++) a[i] = d[4+32*i +: 32];
        for (int i = 0; i < 3; i++) b[i] = d[132+32*i +: 32];
        f = d[228 +: 32];
        r = '0;
        r.ok = 1'b1;
        v[0] = 0; v[1] = 0; v[2] = 0;
        case (op)
            OP_NEG: begin
                for (int i = 0; i < 3; i++) v[i] = clamp(-66'(a[i]));
                r.w = a[3];
            end
            OP_DOT: begin
                acc = 66'(a[0]) * b[0] + 66'(a[1]) * b[1] + 66'(a[2]) * b[2];
                r.dot = clamp(acc >>> FRAC);
            end
            OP_CROSS, OP_NORMAL: begin
                v[0] = clamp((66'(a[1]) * b[2] - 66'(a[2]) * b[1]) >>> FRAC);
                v[1] = clamp((66'(a[2]) * b[0] - 66'(a[0]) * b[2]) >>> FRAC);
                v[2] = clamp((66'(a[0]) * b[1] - 66'(a[1]) * b[0]) >>> FRAC);
                if (op == OP_CROSS) r.w = a[3];
                else r.ok = unit_vec(nz, v);
            end
            OP_NORM: begin
                for (int i = 0; i < 3; i++) v[i] = a[i];
                r.ok = unit_vec(nz, v);
                if (!r.ok) r.w = a[3];
            end
            OP_HOMO: begin
                if (a[3] == 0 || mag32(a[3]) < nz) begin
                    for (int i = 0; i < 3; i++) v[i] = a[i];
                    r.w = a[3];
                    r.ok = 1'b0;
                end else begin
                    for (int i = 0; i < 3; i++) v[i] = fix_div(a[i], mag32(a[3]), a[3][31]);
                    r.w = 32'sd1 << FRAC;
                end
            end
            OP_ADD: begin
                for (int i = 0; i < 3; i++) v[i] = clamp(66'(a[i]) + b[i]);
                r.w = a[3];
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) v[i] = clamp(66'(a[i]) - b[i]);
                r.w = a[3];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) v[i] = clamp((66'(a[i]) * f) >>> FRAC);
                r.w = a[3];
            end
            default: r.ok = 1'b0;
        endcase
        r.x = v[0]; r.y = v[1]; r.z = v[2];
        return r;
    endfunction

    assign pending = result_q.size();

    always @(posedge aclk) begin
        alu_result_t exp_r, got;
        logic [31:0] e, g;
        if (!aresetn) begin
            threshold <= 16'd1;
            fail_count <= 0;
            result_q.delete();
        end else begin
            if (s_tvalid && s_tready) result_q.push_back(alu_predict(s_tdata, threshold));
            if (m_tvalid && m_tready) begin
                got = m_tdata[160:0];
                if (result_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = result_q.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        e = (i == 5) ? {31'd0, exp_r.ok} : exp_r[32*i +: 32];
                        g = (i == 5) ? {31'd0, got.ok} : got[32*i +: 32];
                        if (e !== g)
                            $display("%0t: field %0d expected %h actual %h", $time, i, e, g);
                    end
                    if (got !== exp_r) fail_count <= fail_count + 1;
                end
            end
            if (cfg_wr_en) threshold <= cfg_wr_data;
        end
    end
endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives vector3_alu with directed and random beats under varying near_zero
// settings and back-pressure; the checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import va_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [NZ_W-1:0]      cfg_wr_data = '0;
    int                   fail_count;
    int                   pending;
    int                   send_idle = 0;
    int                   recv_stall = 0;

    always #4 aclk = ~aclk;

    vector3_alu i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    vector3_alu_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic send_beat(input logic [OP_W-1:0] op, input word_t ax, input word_t ay,
                             input word_t az, input word_t aw, input word_t bx,
                             input word_t by, input word_t bz, input word_t f);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'd0, f, bz, by, bx, aw, az, ay, ax, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic set_threshold(input logic [NZ_W-1:0] nz);
        s_tvalid <= 1'b0;
        // let the checker book the last accepted beat first
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= nz;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(4))
            0: return $urandom();
            1: return $signed($urandom_range(2097151)) - 32'sd1048576;
            2: return $signed($urandom_range(600)) - 32'sd300;
            3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $signed($urandom_range(8)) <<< 16;
        endcase
    endfunction

    task automatic send_random();
        logic [OP_W-1:0] op;
        word_t ax, ay, az, s;
        op = ($urandom_range(19) == 0) ? OP_W'($urandom_range(15)) : OP_W'($urandom_range(8));
        ax = rand_word(); ay = rand_word(); az = rand_word();
        s = rand_word();
        // nearly parallel operands give a cross product near zero
        if (op inside {OP_CROSS, OP_NORMAL} && $urandom_range(5) == 0)
            send_beat(op, ax, ay, az, rand_word(), ax >>> 2, ay >>> 2, az >>> 2, s);
        else
            send_beat(op, ax, ay, az, rand_word(), rand_word(), rand_word(), rand_word(), s);
    endtask

    initial begin
        logic [NZ_W-1:0] nz_set[5];
        nz_set = '{16'd0, 16'hFFFF, 16'd1000, 16'd0, 16'd1};
        nz_set[3] = NZ_W'($urandom());
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_threshold(16'd1);
        // directed: every op, extremes, degenerate cases
        for (int op = 0; op < 16; op++)
            send_beat(OP_W'(op), 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 32'sh00020000,
                      32'sh80000000, 32'sh7FFFFFFF, 32'shFFFF0000, 32'sh80000000);
        send_beat(OP_NEG, 32'sh80000000, 0, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0);
        send_beat(OP_NORM, 0, 0, 0, 32'sh12345678, 0, 0, 0, 0);
        send_beat(OP_NORM, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0, 0);
        send_beat(OP_HOMO, 32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0, 0, 0);
        send_beat(OP_HOMO, 32'sh80000000, 32'sh7FFFFFFF, 5, 32'shFFFFFFFF, 0, 0, 0, 0);
        send_beat(OP_NORMAL, 32'sh10000, 32'sh20000, 32'sh30000, 0,
                  32'sh20000, 32'sh40000, 32'sh60000, 0);
        send_beat(OP_DOT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        send_beat(OP_SCALE, 32'sh7FFFFFFF, 32'sh80000000, 3, 7, 0, 0, 0, 32'sh80000000);
        set_threshold(16'hFFFF);
        send_beat(OP_NORM, 32'sh100, 32'sh200, 0, 9, 0, 0, 0, 0);
        send_beat(OP_HOMO, 1, 2, 3, 32'shFFFF0001, 0, 0, 0, 0);
        send_beat(OP_NORMAL, 32'sh100, 0, 0, 0, 0, 32'sh100, 0, 0);
        for (int ph = 0; ph < 5; ph++) begin
            set_threshold(nz_set[ph]);
            for (int n = 0; n < 345; n++) begin
                case ((n / 40) % 4)
                    0: begin send_idle = 0; recv_stall = 0; end
                    1: begin send_idle = 69; recv_stall = 0; end
                    2: begin send_idle = 0; recv_stall = 69; end
                    default: begin send_idle = 24; recv_stall = 24; end
                endcase
                send_random();
            end
        end
        s_tvalid <= 1'b0;
        recv_stall = 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire
